// ===== design/lcg_range_draw_diameter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LCG range draw diameter unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LCG_RANGE_DRAW_DIAMETER_UNIT_MACROS_SVH
`define LCG_RANGE_DRAW_DIAMETER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define LRD_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcg range draw check failed");

// cons must hold in the cycle after ante
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcg range draw check failed");

`else

`define LRD_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define LRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/lcgrd_pkg.sv =====
// ----------------------------------------------------------------------------
// LCG range draw package
// Widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgrd_pkg;

    localparam int GEN_W     = 31;  // generator value
    localparam int MOD_W     = 32;  // modulus
    localparam int RANGE_W   = 16;  // draw range and counters
    localparam int PROD_W    = 2 * GEN_W;
    localparam int DIVD_W    = PROD_W + 1;  // a*r + c
    localparam int SCALE_W   = GEN_W + RANGE_W;  // r * n
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int TDATA_W   = 64;

    localparam logic [STEP_W-1:0] MOD_STEPS   = STEP_W'(DIVD_W);
    localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(SCALE_W);

    localparam logic [MOD_W-1:0] MOD_CAP = 32'h8000_0000;

    localparam logic [GEN_W-1:0]   RST_MULTIPLIER = 31'd1103515245;
    localparam logic [GEN_W-1:0]   RST_INCREMENT  = 31'd12345;
    localparam logic [MOD_W-1:0]   RST_MODULUS    = 32'h8000_0000;
    localparam logic [GEN_W-1:0]   RST_SEED       = 31'd1;
    localparam logic [RANGE_W-1:0] RST_RANGE_TOP  = 16'd6;
    localparam logic [RANGE_W-1:0] RST_DRAWS      = 16'd1;
    localparam logic [RANGE_W-1:0] RST_SEQUENCES  = 16'd1;

    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_TOP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRAWS_PER_SEQ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_TOTAL = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GEN,
        ST_LOAD_MOD,
        ST_DIV_MOD,
        ST_MUL_SCALE,
        ST_LOAD_SCALE,
        ST_DIV_SCALE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== design/lcg_range_draw_diameter_unit.sv =====
// ----------------------------------------------------------------------------
// LCG range draw diameter unit
// Linear congruential generator scaled to 1..n, with per-sequence diameter.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata[0] reseed
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata, tlast, tuser
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  A request passes from accept to result through one shared 31x31
//  multiplier and one restoring divider, one bit per cycle, which runs 63
//  steps for the modulus and 47 steps for the range scaling.
//  s_axis_tready is high only when the sequencer is idle; the result sits in
//  an output register, so a new request may start while it waits.
//  Reset (synchronous, active low) loads default registers and the seed.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lcg_range_draw_diameter_unit_macros.svh"

module lcg_range_draw_diameter_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [0] reseed
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] drawn_value, [46:16] raw_value, [62:47] diameter, [63] zero
    output logic [lcgrd_pkg::TDATA_W-1:0]            m_axis_tdata,
    output logic                                     m_axis_tlast,  // last_in_sequence
    output logic                                     m_axis_tuser,  // [0] last_of_batch
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lcgrd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lcgrd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int GEN_W   = lcgrd_pkg::GEN_W;
    localparam int MOD_W   = lcgrd_pkg::MOD_W;
    localparam int RANGE_W = lcgrd_pkg::RANGE_W;
    localparam int PROD_W  = lcgrd_pkg::PROD_W;
    localparam int DIVD_W  = lcgrd_pkg::DIVD_W;
    localparam int SCALE_W = lcgrd_pkg::SCALE_W;
    localparam int STEP_W  = lcgrd_pkg::STEP_W;

    // configuration registers
    logic [GEN_W-1:0]   r_mult;
    logic [GEN_W-1:0]   r_incr;
    logic [MOD_W-1:0]   r_mod;
    logic [GEN_W-1:0]   r_seed;
    logic [RANGE_W-1:0] r_range;
    logic [RANGE_W-1:0] r_draws;
    logic [RANGE_W-1:0] r_seqs;

    // sequencer and datapath
    lcgrd_pkg::t_state r_state, n_state;
    logic [GEN_W-1:0]   r_gen, n_gen;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [DIVD_W-1:0]  r_div, n_div;
    logic [GEN_W-1:0]   r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [RANGE_W-1:0] r_draw_idx, n_draw_idx;
    logic [RANGE_W-1:0] r_seq_idx, n_seq_idx;
    logic [RANGE_W-1:0] r_min, n_min;
    logic [RANGE_W-1:0] r_max, n_max;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [lcgrd_pkg::TDATA_W-1:0] r_out_data, n_out_data;
    logic                         r_out_last, n_out_last;
    logic                         r_out_user, n_out_user;

    // effective configuration
    logic [MOD_W-1:0]   w_mod_eff;
    logic [RANGE_W-1:0] w_range_eff;
    logic [RANGE_W-1:0] w_draws_eff;
    logic [RANGE_W-1:0] w_seqs_eff;

    // shared multiplier
    logic [GEN_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_mul_p;

    // shared divider step
    logic [MOD_W-1:0]  w_trial;
    logic              w_fit;
    logic [MOD_W-1:0]  w_diff;
    logic [GEN_W-1:0]  w_rem_step;

    // finish stage
    logic [RANGE_W-1:0] w_draw;
    logic [RANGE_W-1:0] w_min_base;
    logic [RANGE_W-1:0] w_max_base;
    logic [RANGE_W-1:0] w_min_upd;
    logic [RANGE_W-1:0] w_max_upd;
    logic [RANGE_W-1:0] w_diam;
    logic               w_end_seq;
    logic               w_end_batch;

    assign w_mod_eff   = (r_mod == '0 || r_mod > lcgrd_pkg::MOD_CAP) ? lcgrd_pkg::MOD_CAP
                                                                    : r_mod;
    assign w_range_eff = (r_range == '0) ? RANGE_W'(1) : r_range;
    assign w_draws_eff = (r_draws == '0) ? RANGE_W'(1) : r_draws;
    assign w_seqs_eff  = (r_seqs == '0) ? RANGE_W'(1) : r_seqs;

    assign w_mul_a = (r_state == lcgrd_pkg::ST_MUL_SCALE)
                   ? {{(GEN_W-RANGE_W){1'b0}}, w_range_eff} : r_mult;
    assign w_mul_p = w_mul_a * r_gen;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial    = {r_rem, r_div[DIVD_W-1]};
    assign w_fit      = (w_trial >= w_mod_eff);
    assign w_diff     = w_trial - w_mod_eff;
    assign w_rem_step = w_fit ? w_diff[GEN_W-1:0] : w_trial[GEN_W-1:0];

    // quotient is below n, so its low bits hold it whole
    assign w_draw     = r_div[RANGE_W-1:0] + RANGE_W'(1);
    assign w_min_base = (r_draw_idx == '0) ? w_range_eff : r_min;
    assign w_max_base = (r_draw_idx == '0) ? RANGE_W'(1) : r_max;
    assign w_min_upd  = (w_draw < w_min_base) ? w_draw : w_min_base;
    assign w_max_upd  = (w_draw > w_max_base) ? w_draw : w_max_base;
    assign w_diam     = w_max_upd - w_min_upd + RANGE_W'(1);
    assign w_end_seq  = ({1'b0, r_draw_idx} + (RANGE_W+1)'(1)) >= {1'b0, w_draws_eff};
    assign w_end_batch = w_end_seq
                       && (({1'b0, r_seq_idx} + (RANGE_W+1)'(1)) >= {1'b0, w_seqs_eff});

    assign s_axis_tready = (r_state == lcgrd_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult  <= lcgrd_pkg::RST_MULTIPLIER;
            r_incr  <= lcgrd_pkg::RST_INCREMENT;
            r_mod   <= lcgrd_pkg::RST_MODULUS;
            r_seed  <= lcgrd_pkg::RST_SEED;
            r_range <= lcgrd_pkg::RST_RANGE_TOP;
            r_draws <= lcgrd_pkg::RST_DRAWS;
            r_seqs  <= lcgrd_pkg::RST_SEQUENCES;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcgrd_pkg::REG_MULTIPLIER:     r_mult  <= i_cfg_data[GEN_W-1:0];
                lcgrd_pkg::REG_INCREMENT:      r_incr  <= i_cfg_data[GEN_W-1:0];
                lcgrd_pkg::REG_MODULUS:        r_mod   <= i_cfg_data[MOD_W-1:0];
                lcgrd_pkg::REG_SEED:           r_seed  <= i_cfg_data[GEN_W-1:0];
                lcgrd_pkg::REG_RANGE_TOP:      r_range <= i_cfg_data[RANGE_W-1:0];
                lcgrd_pkg::REG_DRAWS_PER_SEQ:  r_draws <= i_cfg_data[RANGE_W-1:0];
                lcgrd_pkg::REG_SEQUENCE_TOTAL: r_seqs  <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcgrd_pkg::ST_IDLE;
            r_gen       <= lcgrd_pkg::RST_SEED;
            r_draw_idx  <= '0;
            r_seq_idx   <= '0;
            r_min       <= lcgrd_pkg::RST_RANGE_TOP;
            r_max       <= RANGE_W'(1);
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_draw_idx  <= n_draw_idx;
            r_seq_idx   <= n_seq_idx;
            r_min       <= n_min;
            r_max       <= n_max;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_prod      = r_prod;
        n_div       = r_div;
        n_rem       = r_rem;
        n_step      = r_step;
        n_draw_idx  = r_draw_idx;
        n_seq_idx   = r_seq_idx;
        n_min       = r_min;
        n_max       = r_max;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lcgrd_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tdata[0]) begin
                        n_gen      = r_seed;
                        n_draw_idx = '0;
                        n_seq_idx  = '0;
                        n_min      = r_range;
                        n_max      = RANGE_W'(1);
                    end
                    n_state = lcgrd_pkg::ST_MUL_GEN;
                end
            end
            lcgrd_pkg::ST_MUL_GEN: begin
                n_prod  = w_mul_p;
                n_state = lcgrd_pkg::ST_LOAD_MOD;
            end
            lcgrd_pkg::ST_LOAD_MOD: begin
                n_div   = {1'b0, r_prod} + {{(DIVD_W-GEN_W){1'b0}}, r_incr};
                n_rem   = '0;
                n_step  = lcgrd_pkg::MOD_STEPS;
                n_state = lcgrd_pkg::ST_DIV_MOD;
            end
            lcgrd_pkg::ST_DIV_MOD: begin
                n_div  = {r_div[DIVD_W-2:0], w_fit};
                n_rem  = w_rem_step;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    // remainder is the new generator value
                    n_gen   = w_rem_step;
                    n_state = lcgrd_pkg::ST_MUL_SCALE;
                end
            end
            lcgrd_pkg::ST_MUL_SCALE: begin
                n_prod  = w_mul_p;
                n_state = lcgrd_pkg::ST_LOAD_SCALE;
            end
            lcgrd_pkg::ST_LOAD_SCALE: begin
                // left-align r*n so only its bits pass through the divider
                n_div   = {r_prod[SCALE_W-1:0], {(DIVD_W-SCALE_W){1'b0}}};
                n_rem   = '0;
                n_step  = lcgrd_pkg::SCALE_STEPS;
                n_state = lcgrd_pkg::ST_DIV_SCALE;
            end
            lcgrd_pkg::ST_DIV_SCALE: begin
                n_div  = {r_div[DIVD_W-2:0], w_fit};
                n_rem  = w_rem_step;
                n_step = r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    n_state = lcgrd_pkg::ST_FINISH;
                end
            end
            lcgrd_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, w_diam, r_gen, w_draw};
                    n_out_last  = w_end_seq;
                    n_out_user  = w_end_batch;
                    n_min       = w_min_upd;
                    n_max       = w_max_upd;
                    if (w_end_seq) begin
                        n_draw_idx = '0;
                        n_seq_idx  = w_end_batch ? '0 : r_seq_idx + RANGE_W'(1);
                    end else begin
                        n_draw_idx = r_draw_idx + RANGE_W'(1);
                    end
                    n_state = lcgrd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    `LRD_ASSERT_HOLDS(a_div_step_live, i_clk, i_rst_n, (r_state == lcgrd_pkg::ST_DIV_MOD || r_state == lcgrd_pkg::ST_DIV_SCALE), (r_step != '0))
    `LRD_ASSERT_HOLDS(a_rem_below_mod, i_clk, i_rst_n, (r_state == lcgrd_pkg::ST_DIV_MOD || r_state == lcgrd_pkg::ST_DIV_SCALE), ({1'b0, r_rem} < w_mod_eff))
    `LRD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready), (r_state == lcgrd_pkg::ST_MUL_GEN))
    `LRD_ASSERT_NEXT(a_finish_emits, i_clk, i_rst_n, (r_state == lcgrd_pkg::ST_FINISH && (!r_out_valid || m_axis_tready)), (m_axis_tvalid && r_state == lcgrd_pkg::ST_IDLE))
    `LRD_ASSERT_HOLDS(a_result_nonzero, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[15:0] != '0 && m_axis_tdata[62:47] != '0))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// LCG range draw diameter unit testbench
// Walks a directed table of draw requests and register writes, then runs
// random phases of register settings and draws under random stalls on both
// stream sides. Every result is checked field by field against an in-bench
// model of generator, range scaling and sequence counters, or a fixed draw.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int GEN_W     = lcgrd_pkg::GEN_W;
    localparam int MOD_W     = lcgrd_pkg::MOD_W;
    localparam int RANGE_W   = lcgrd_pkg::RANGE_W;
    localparam int CFG_IDX_W = lcgrd_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = lcgrd_pkg::CFG_DAT_W;
    localparam int TDATA_W   = lcgrd_pkg::TDATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unmapped index
    localparam int PLAN_LEN   = 48;
    localparam int RAND_DRAWS = 1300;
    localparam int DRAIN_CYC  = 130;

    typedef struct packed {
        logic [RANGE_W-1:0] drawn;
        logic [GEN_W-1:0]   raw;
        logic [RANGE_W-1:0] diam;
        logic               last_seq;
        logic               last_batch;
    } t_draw;

    typedef enum logic {ROW_CFG, ROW_DRAW} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic                 reseed;
        logic                 typed;
        t_draw                want;
    } t_row;

    localparam t_draw DRAW_RESET  = '{16'd4, 31'd1103527590, 16'd1, 1'b1, 1'b1};
    localparam t_draw DRAW_TOP    = '{16'hFFFF, 31'h7FFF_FFFF, 16'd1, 1'b1, 1'b1};
    localparam t_draw DRAW_BOTTOM = '{16'd1, 31'd0, 16'd1, 1'b1, 1'b1};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [0] reseed
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [TDATA_W-1:0]     m_axis_tdata;        // [15:0] drawn, [46:16] raw, [62:47] diameter
    logic                   m_axis_tlast;        // last_in_sequence
    logic                   m_axis_tuser;        // [0] last_of_batch
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    lcg_range_draw_diameter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // model registers and generator state
    logic [GEN_W-1:0]   p_mult, p_inc, p_seed, gen_val;
    logic [MOD_W-1:0]   p_mod;
    logic [RANGE_W-1:0] p_top, p_k, p_total;
    logic [RANGE_W-1:0] draw_idx, seq_idx, run_min, run_max;

    t_draw draws_due[$];
    t_draw head;
    t_row  plan [PLAN_LEN];
    int    mismatch_count = 0;
    int    rx_hold = 0;
    bit    tx_fast = 1'b0;
    bit    rx_fast = 1'b0;

    function automatic t_draw predict_draw(input logic reseed);
        longint unsigned m, n, k, total, r, f;
        t_draw res;
        m     = (p_mod == '0 || p_mod > lcgrd_pkg::MOD_CAP) ? 64'(lcgrd_pkg::MOD_CAP)
                                                           : 64'(p_mod);
        n     = (p_top == '0) ? 64'd1 : 64'(p_top);
        k     = (p_k == '0) ? 64'd1 : 64'(p_k);
        total = (p_total == '0) ? 64'd1 : 64'(p_total);
        if (reseed) begin
            gen_val  = p_seed;
            draw_idx = '0;
            seq_idx  = '0;
            run_min  = p_top;
            run_max  = 16'd1;
        end
        if (draw_idx == '0) begin
            run_min = RANGE_W'(n);
            run_max = 16'd1;
        end
        r = (64'(p_mult) * 64'(gen_val) + 64'(p_inc)) % m;
        f = r * n / m + 64'd1;
        if (f > 64'(run_max)) run_max = RANGE_W'(f);
        if (f < 64'(run_min)) run_min = RANGE_W'(f);
        gen_val        = GEN_W'(r);
        res.drawn      = RANGE_W'(f);
        res.raw        = GEN_W'(r);
        res.diam       = run_max - run_min + 16'd1;
        res.last_seq   = (64'(draw_idx) + 64'd1) >= k;
        res.last_batch = res.last_seq && ((64'(seq_idx) + 64'd1) >= total);
        if (res.last_seq) begin
            draw_idx = '0;
            seq_idx  = res.last_batch ? '0 : seq_idx + 16'd1;
        end else begin
            draw_idx = draw_idx + 16'd1;
        end
        return res;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DAT_W-1:0] data);
        return '{ROW_CFG, idx, data, 1'b0, 1'b0, '0};
    endfunction

    function automatic t_row draw_row(input logic reseed);
        return '{ROW_DRAW, REG_NONE, 32'd0, reseed, 1'b0, '0};
    endfunction

    function automatic t_row typed_row(input logic reseed, input t_draw want);
        return '{ROW_DRAW, REG_NONE, 32'd0, reseed, 1'b1, want};
    endfunction

    // mostly small counts and moduli, with the extremes mixed in
    function automatic logic [CFG_DAT_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] ri);
        logic [CFG_DAT_W-1:0] v;
        v = $urandom;
        case (ri)
            lcgrd_pkg::REG_MULTIPLIER, lcgrd_pkg::REG_INCREMENT, lcgrd_pkg::REG_SEED: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = 32'h7FFF_FFFF;
                    default: ;
                endcase
            end
            lcgrd_pkg::REG_MODULUS: begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = lcgrd_pkg::MOD_CAP;
                    2: v = $urandom_range(1, 1000);
                    3: v = 32'd1;
                    4: v = v >> $urandom_range(0, 31);
                    default: ;
                endcase
            end
            lcgrd_pkg::REG_RANGE_TOP: begin
                case ($urandom_range(0, 5))
                    0: v[15:0] = '0;
                    1: v[15:0] = 16'hFFFF;
                    2: v[15:0] = 16'd1;
                    3, 4: v[15:0] = 16'($urandom_range(2, 20));
                    default: ;
                endcase
            end
            lcgrd_pkg::REG_DRAWS_PER_SEQ, lcgrd_pkg::REG_SEQUENCE_TOTAL: begin
                case ($urandom_range(0, 7))
                    0: v[15:0] = '0;
                    1: v[15:0] = 16'hFFFF;
                    2: ;
                    default: v[15:0] = 16'($urandom_range(1, 8));
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        // hold until the unit has drained every request
        while (draws_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lcgrd_pkg::REG_MULTIPLIER:     p_mult  = val[GEN_W-1:0];
            lcgrd_pkg::REG_INCREMENT:      p_inc   = val[GEN_W-1:0];
            lcgrd_pkg::REG_MODULUS:        p_mod   = val;
            lcgrd_pkg::REG_SEED:           p_seed  = val[GEN_W-1:0];
            lcgrd_pkg::REG_RANGE_TOP:      p_top   = val[RANGE_W-1:0];
            lcgrd_pkg::REG_DRAWS_PER_SEQ:  p_k     = val[RANGE_W-1:0];
            lcgrd_pkg::REG_SEQUENCE_TOTAL: p_total = val[RANGE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_draw(input logic reseed, input logic typed, input t_draw want);
        int unsigned gap;
        t_draw got;
        gap = tx_fast ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            // half the time count the gap from the unit going idle
            if ($urandom_range(0, 1)) do @(posedge i_clk); while (!s_axis_tready);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, reseed};
        do @(posedge i_clk); while (!s_axis_tready);
        got = predict_draw(reseed);
        draws_due.push_back(typed ? want : got);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // output side: stall for a random count after each accepted result
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            rx_hold = rx_fast ? 0 : $urandom_range(0, 19);
            if (rx_hold != 0) m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            if (rx_hold == 0) m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (draws_due.size() == 0) begin
                $display("%0t: result with no request pending, expected none got %0h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                head = draws_due.pop_front();
                compare_field("drawn_value", 64'(head.drawn), 64'(m_axis_tdata[15:0]));
                compare_field("raw_value", 64'(head.raw), 64'(m_axis_tdata[46:16]));
                compare_field("diameter", 64'(head.diam), 64'(m_axis_tdata[62:47]));
                compare_field("tdata pad", 64'd0, 64'(m_axis_tdata[63]));
                compare_field("last_in_sequence", 64'(head.last_seq), 64'(m_axis_tlast));
                compare_field("last_of_batch", 64'(head.last_batch), 64'(m_axis_tuser));
            end
        end
    end

    initial begin
        int rand_draws;
        int len;

        p_mult   = lcgrd_pkg::RST_MULTIPLIER;
        p_inc    = lcgrd_pkg::RST_INCREMENT;
        p_mod    = lcgrd_pkg::RST_MODULUS;
        p_seed   = lcgrd_pkg::RST_SEED;
        p_top    = lcgrd_pkg::RST_RANGE_TOP;
        p_k      = lcgrd_pkg::RST_DRAWS;
        p_total  = lcgrd_pkg::RST_SEQUENCES;
        gen_val  = lcgrd_pkg::RST_SEED;
        draw_idx = '0;
        seq_idx  = '0;
        run_min  = lcgrd_pkg::RST_RANGE_TOP;
        run_max  = 16'd1;
        rand_draws = 0;

        plan = '{
            typed_row(1'b0, DRAW_RESET),
            typed_row(1'b1, DRAW_RESET),
            cfg_row(lcgrd_pkg::REG_SEED, 32'd5),            // no effect until a reseed
            draw_row(1'b0),
            draw_row(1'b1),
            cfg_row(lcgrd_pkg::REG_MULTIPLIER, 32'd0),
            cfg_row(lcgrd_pkg::REG_INCREMENT, 32'hFFFF_FFFF),
            cfg_row(lcgrd_pkg::REG_RANGE_TOP, 32'h0000_FFFF),
            typed_row(1'b0, DRAW_TOP),
            cfg_row(lcgrd_pkg::REG_INCREMENT, 32'd0),
            typed_row(1'b0, DRAW_BOTTOM),
            cfg_row(lcgrd_pkg::REG_RANGE_TOP, 32'd0),       // zero range behaves as one
            typed_row(1'b0, DRAW_BOTTOM),
            cfg_row(lcgrd_pkg::REG_RANGE_TOP, 32'h0000_FFFF),
            cfg_row(lcgrd_pkg::REG_INCREMENT, 32'h7FFF_FFFF),
            cfg_row(lcgrd_pkg::REG_MODULUS, 32'd0),         // saturates to the cap
            typed_row(1'b0, DRAW_TOP),
            cfg_row(lcgrd_pkg::REG_MODULUS, 32'hFFFF_FFFF),
            typed_row(1'b0, DRAW_TOP),
            cfg_row(lcgrd_pkg::REG_MODULUS, 32'd1),
            typed_row(1'b0, DRAW_BOTTOM),
            cfg_row(REG_NONE, 32'hFFFF_FFFF),
            typed_row(1'b0, DRAW_BOTTOM),
            cfg_row(lcgrd_pkg::REG_MODULUS, 32'd1000),
            cfg_row(lcgrd_pkg::REG_MULTIPLIER, 32'h7FFF_FFFF),
            cfg_row(lcgrd_pkg::REG_DRAWS_PER_SEQ, 32'd3),
            cfg_row(lcgrd_pkg::REG_SEQUENCE_TOTAL, 32'd2),
            cfg_row(lcgrd_pkg::REG_SEED, 32'h7FFF_FFFF),    // seed above the modulus
            draw_row(1'b1),
            draw_row(1'b0),
            draw_row(1'b0),
            draw_row(1'b0),
            draw_row(1'b0),
            draw_row(1'b0),
            cfg_row(lcgrd_pkg::REG_DRAWS_PER_SEQ, 32'd5),
            draw_row(1'b0),
            draw_row(1'b0),
            draw_row(1'b0),
            cfg_row(lcgrd_pkg::REG_DRAWS_PER_SEQ, 32'd2),   // lowered below the draw index
            draw_row(1'b0),
            draw_row(1'b0),
            cfg_row(lcgrd_pkg::REG_DRAWS_PER_SEQ, 32'd0),
            cfg_row(lcgrd_pkg::REG_SEQUENCE_TOTAL, 32'd0),
            draw_row(1'b0),
            cfg_row(lcgrd_pkg::REG_DRAWS_PER_SEQ, 32'h0000_FFFF),
            cfg_row(lcgrd_pkg::REG_SEQUENCE_TOTAL, 32'h0000_FFFF),
            draw_row(1'b1),
            draw_row(1'b0)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_draw(plan[i].reseed, plan[i].typed, plan[i].want);
            end
        end

        while (rand_draws < RAND_DRAWS) begin
            for (int ri = int'(lcgrd_pkg::REG_MULTIPLIER);
                 ri <= int'(lcgrd_pkg::REG_SEQUENCE_TOTAL); ri++) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(CFG_IDX_W'(ri), pick_value(CFG_IDX_W'(ri)));
                end
            end
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            len = $urandom_range(10, 60);
            send_draw(1'($urandom_range(0, 1)), 1'b0, '0);
            rand_draws++;
            repeat (len) begin
                if ($urandom_range(0, 31) == 0) begin
                    // drain every pending request before the next one
                    s_axis_tvalid <= 1'b0;
                    while (draws_due.size() != 0) @(posedge i_clk);
                end
                send_draw($urandom_range(0, 15) == 0, 1'b0, '0);
                rand_draws++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (draws_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("lcg_range_draw_diameter_unit verification clean");
        end else begin
            $display("lcg_range_draw_diameter_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("lcg_range_draw_diameter_unit verification failed");
        $finish;
    end

endmodule
